// ----- rtl/core/aes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, S-box tables and round functions for the AES-128 core.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned BLOCK_W    = 128;
    localparam int unsigned HALF_W     = 64;

    localparam logic [0:0] CMD_ENCRYPT = 1'b0;
    localparam logic [0:0] CMD_DECRYPT = 1'b1;

    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;

    // Stage control that travels with each block
    typedef struct packed {
        logic valid;
        logic decrypt;
    } stage_ctl_t;

    // Multiply by x modulo the field polynomial
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Byte i of a block sits in bits 127-8i downto 120-8i
    function automatic logic [7:0] get_byte(input block_t s, input int unsigned i);
        get_byte = s[BLOCK_W-1-8*i -: 8];
    endfunction

    // One key-schedule step: round key n from round key n-1
    function automatic block_t next_round_key(input block_t k, input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX_FWD[w3[23:16]] ^ rcon, SBOX_FWD[w3[15:8]],
              SBOX_FWD[w3[7:0]], SBOX_FWD[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

    // SubBytes and ShiftRows, forward or inverse
    function automatic block_t sub_shift(input block_t s, input logic inv);
        block_t t;
        int unsigned c, r;
        t = '0;
        for (c = 0; c < 4; c++) begin
            for (r = 0; r < 4; r++) begin
                if (inv)
                    t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX_INV[get_byte(s, 4*((c-r+4)%4)+r)];
                else
                    t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX_FWD[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        sub_shift = t;
    endfunction

    // MixColumns, forward or inverse
    function automatic block_t mix(input block_t s, input logic inv);
        block_t t;
        logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1, y2, y3;
        int unsigned c;
        t = '0;
        for (c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            if (inv) begin
                // Pre-multiply so the forward matrix yields the inverse
                x0 = xtime(xtime(a0 ^ a2));
                x1 = xtime(xtime(a1 ^ a3));
                a0 = a0 ^ x0;
                a1 = a1 ^ x1;
                a2 = a2 ^ x0;
                a3 = a3 ^ x1;
            end
            y0 = a0 ^ a1 ^ a2 ^ a3;
            x0 = xtime(a0 ^ a1);
            x1 = xtime(a1 ^ a2);
            x2 = xtime(a2 ^ a3);
            x3 = xtime(a3 ^ a0);
            y1 = a0 ^ x0 ^ y0;
            y2 = a1 ^ x1 ^ y0;
            y3 = a2 ^ x2 ^ y0;
            t[BLOCK_W-1-8*(4*c)   -: 8] = y1;
            t[BLOCK_W-1-8*(4*c+1) -: 8] = y2;
            t[BLOCK_W-1-8*(4*c+2) -: 8] = y3;
            t[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ x3 ^ y0;
        end
        mix = t;
    endfunction

endpackage

// ----- rtl/core/aes_key_sched.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_key_sched
// Holds the key registers and expands all eleven round keys, one key-schedule
// step per register stage, after each configuration write.
// ----------------------------------------------------------------------------
module aes_key_sched
    import aes_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [0:0]                     wr_index,
    input  logic [aes_pkg::HALF_W-1:0]     wr_data,
    output aes_pkg::block_t                rkey [aes_pkg::NUM_ROUNDS+1],
    output logic                           keys_ready
);

    // Cycles until the last round key reflects the key registers
    localparam logic [3:0] SETTLE_CYCLES = 4'(NUM_ROUNDS + 1);

    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;
    block_t            rk_reg [NUM_ROUNDS+1];
    logic [7:0]        rcon   [NUM_ROUNDS];
    logic [3:0]        settle_reg;

    // Take key writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_KEY_HIGH)
                key_high_reg <= wr_data;
            else
                key_low_reg <= wr_data;
        end
    end

    // Round constants
    always_comb
    begin
        rcon[0] = 8'h01;
        for (int i = 1; i < NUM_ROUNDS; i++)
            rcon[i] = xtime(rcon[i-1]);
    end

    // Expand one round key per stage, starting from the key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rk_reg <= '{default: '0};
        end
        else
        begin
            rk_reg[0] <= {key_high_reg, key_low_reg};
            for (int i = 1; i <= NUM_ROUNDS; i++)
                rk_reg[i] <= next_round_key(rk_reg[i-1], rcon[i-1]);
        end
    end

    // Count down the expansion after reset and after every write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE_CYCLES;
        else if (wr_en)
            settle_reg <= SETTLE_CYCLES;
        else if (settle_reg != 4'd0)
            settle_reg <= settle_reg - 4'd1;
    end

    assign rkey       = rk_reg;
    assign keys_ready = (settle_reg == 4'd0);

endmodule

// ----- rtl/core/aes_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round
// One registered cipher round, encrypt or decrypt, with its own valid bit.
// ----------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                last,
    input  aes_pkg::stage_ctl_t ctl_in,
    input  aes_pkg::block_t     state_in,
    input  aes_pkg::block_t     key_enc,
    input  aes_pkg::block_t     key_dec,
    output aes_pkg::stage_ctl_t ctl_out,
    output aes_pkg::block_t     state_out
);

    stage_ctl_t ctl_reg;
    block_t     state_reg;
    block_t     state_next;
    block_t     ss;

    // Encrypt: sub/shift, mix, add key. Decrypt: sub/shift, add key, mix. Last round: no mix.
    always_comb
    begin
        ss = sub_shift(state_in, ctl_in.decrypt);
        if (last)
            state_next = ss ^ (ctl_in.decrypt ? key_dec : key_enc);
        else if (ctl_in.decrypt)
            state_next = mix(ss ^ key_dec, 1'b1);
        else
            state_next = mix(ss, 1'b0) ^ key_enc;
    end

    // Advance the stage when the pipe moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (advance)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            state_reg <= state_next;
    end

    assign ctl_out   = ctl_reg;
    assign state_out = state_reg;

endmodule

// ----- rtl/core/aes128_block_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_cipher
// AES-128 encrypt/decrypt core: eleven-stage unrolled round pipeline.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_stall  | cmd, data_high, data_low
//  out     | source    | out_valid/out_stall| out_high, out_low
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One block enters per cycle while the input is not stalled; its result reaches
// the output through eleven register stages (key add plus ten rounds, one round
// per stage, each bounded by one S-box and mix layer).
// Reset clears the keys and every stage valid bit. After reset and after every
// key write the input is stalled while the round keys expand.
// The whole pipe holds while the output is stalled with a result waiting;
// empty stages still fill, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module aes128_block_cipher
    import aes_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       cmd,
    input  logic [aes_pkg::HALF_W-1:0] data_high,
    input  logic [aes_pkg::HALF_W-1:0] data_low,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [aes_pkg::HALF_W-1:0] out_high,
    output logic [aes_pkg::HALF_W-1:0] out_low,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [0:0]                 cfg_index,
    input  logic [aes_pkg::HALF_W-1:0] cfg_data
);

    block_t     rkey  [NUM_ROUNDS+1];
    stage_ctl_t ctl   [NUM_ROUNDS+1];
    block_t     st    [NUM_ROUNDS+1];
    logic       adv   [NUM_ROUNDS+1];
    logic       keys_ready;
    stage_ctl_t ctl0_reg;
    block_t     st0_reg;

    assign cfg_ready = 1'b1;

    aes_key_sched u_key (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cfg_valid),
        .wr_index   (cfg_index),
        .wr_data    (cfg_data),
        .rkey       (rkey),
        .keys_ready (keys_ready)
    );

    // Stage n moves when it is empty or the next stage moves
    always_comb
    begin
        adv[NUM_ROUNDS] = !ctl[NUM_ROUNDS].valid || !out_stall;
        for (int i = NUM_ROUNDS - 1; i >= 0; i--)
            adv[i] = !ctl[i].valid || adv[i+1];
    end

    assign in_stall = !adv[0] || !keys_ready;

    // Initial key add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl0_reg <= '0;
        else if (adv[0])
            ctl0_reg <= '{valid: in_valid && keys_ready, decrypt: cmd};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            st0_reg <= {data_high, data_low}
                       ^ ((cmd == CMD_DECRYPT) ? rkey[NUM_ROUNDS] : rkey[0]);
    end

    assign ctl[0] = ctl0_reg;
    assign st[0]  = st0_reg;

    for (genvar g = 1; g <= NUM_ROUNDS; g++)
    begin : g_round
        aes_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (adv[g]),
            .last      (g == NUM_ROUNDS),
            .ctl_in    (ctl[g-1]),
            .state_in  (st[g-1]),
            .key_enc   (rkey[g]),
            .key_dec   (rkey[NUM_ROUNDS-g]),
            .ctl_out   (ctl[g]),
            .state_out (st[g])
        );
    end

    assign out_valid = ctl[NUM_ROUNDS].valid;
    assign out_high  = st[NUM_ROUNDS][BLOCK_W-1:HALF_W];
    assign out_low   = st[NUM_ROUNDS][HALF_W-1:0];

`ifndef ASSERT_OFF
    // Input is stalled only while keys expand or the pipe is full and blocked
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (!keys_ready || (out_valid && out_stall && ctl[0].valid)))
        else $error("input stalled with room in pipe");
    // A blocked result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_high) && $stable(out_low)))
        else $error("stalled result changed");
    // An accepted item lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> ctl[0].valid)
        else $error("accepted item lost");
`endif

endmodule
